// ----- rtl/led_matrix_scan_framebuffer_assert.svh -----
// assertion macros for the led matrix scan frame buffer
`ifndef LED_MATRIX_SCAN_FRAMEBUFFER_ASSERT_SVH
`define LED_MATRIX_SCAN_FRAMEBUFFER_ASSERT_SVH

// clocked assertion, disabled while reset is asserted
`define LMS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// assertion that a condition never occurs
`define LMS_ASSERT_NEVER(label, cond, msg) \
  `LMS_ASSERT(label, !(cond), msg)

`endif

// ----- rtl/lms_pkg.sv -----
// types and constants for the led matrix scan frame buffer
package lms_pkg;

  // command codes
  localparam logic CMD_STORE = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // frame store geometry
  localparam int unsigned StoreDepth = 512;
  localparam int unsigned AddrW      = 9;
  localparam int unsigned Groups     = 8;
  localparam int unsigned GroupW     = 3;

  // power-up frame pattern
  localparam logic [7:0] FILL_EVEN = 8'hAA;
  localparam logic [7:0] FILL_ODD  = 8'h55;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
  } lms_in_t;

  typedef struct packed {
    logic [7:0] group_select;
    logic [7:0] line_select;
    logic [7:0] anode_select;
    logic [7:0] anode_data;
    logic       last;
  } lms_out_t;

endpackage

// ----- rtl/led_matrix_scan_framebuffer.sv -----
// led matrix scan driver with a 512-byte frame store
//
// Input channel (in_valid_i / in_ready_o / in_data_i): a store command writes
// data_byte at the write pointer, which wraps after entry 511; it produces no
// output. A tick command scans the current column and produces eight output
// transfers, one per anode group 0 to 7, the eighth flagged with last.
// Output channel (out_valid_o / out_ready_i / out_data_o) carries the cathode
// group and line selects, the anode group select and that group's frame byte.
// A store leaves the block ready for further input. A tick holds input off
// while its reads are issued: the single read port of the frame store delivers
// one byte per cycle while the receiver is ready, and the first result is
// registered once the tick has moved the block to its scan state and issued
// its first read. Input is refused while a tick is still issuing reads,
// but a new item is taken while the final result waits in the output register.
// A receiver stall holds the output register and pauses the reads.
// Reset clears the write pointer and the scan column and marks the whole
// store as unwritten; unwritten entries read as 0xAA for even columns and 0x55
// for odd columns, so no clearing pass is needed after reset.
module led_matrix_scan_framebuffer #(
  parameter int unsigned COLUMNS = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  lms_pkg::lms_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output lms_pkg::lms_out_t out_data_o
);
  import lms_pkg::*;

  `include "led_matrix_scan_framebuffer_assert.svh"

  localparam int unsigned ColW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  state_e              state_q;
  logic [GroupW-1:0]   grp_q;
  logic [ColW-1:0]     col_q;
  logic [AddrW-1:0]    wr_idx_q;
  logic                wrapped_q;
  logic                out_valid_q;

  // output payload registers
  logic [7:0]          gsel_q;
  logic [7:0]          lsel_q;
  logic [7:0]          asel_q;
  logic                last_q;
  logic                written_q;
  logic [7:0]          fill_q;
  logic [7:0]          rd_q;

  logic [7:0]          mem [StoreDepth];

  logic                in_fire;
  logic                wr_en;
  logic                issue;
  logic [AddrW-1:0]    col_ext;
  logic [AddrW-1:0]    rd_addr;
  logic [7:0]          gsel_d;
  logic [7:0]          lsel_d;

  // handshake and read issue
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign wr_en      = in_fire && (in_data_i.cmd == CMD_STORE);
  assign issue      = (state_q == ST_SCAN) && (!out_valid_q || out_ready_i);

  // address and select decode for the current column
  assign col_ext = AddrW'(col_q);
  assign rd_addr = {col_ext[AddrW-GroupW-1:0], grp_q};
  assign lsel_d  = 8'(1) << col_ext[GroupW-1:0];

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      gsel_d[b] = (col_ext[AddrW-1:GroupW] != 6'(b));
    end
  end

  // control state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      grp_q       <= '0;
      col_q       <= '0;
      wr_idx_q    <= '0;
      wrapped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (issue) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (wr_en) begin
            wr_idx_q <= wr_idx_q + AddrW'(1);
            if (wr_idx_q == AddrW'(StoreDepth - 1)) begin
              wrapped_q <= 1'b1;
            end
          end else if (in_fire) begin
            grp_q   <= '0;
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (issue) begin
            grp_q <= grp_q + GroupW'(1);
            if (grp_q == GroupW'(Groups - 1)) begin
              state_q <= ST_IDLE;
              if (col_q == ColW'(COLUMNS - 1)) begin
                col_q <= '0;
              end else begin
                col_q <= col_q + ColW'(1);
              end
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // frame store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_idx_q] <= in_data_i.data_byte;
    end
    if (issue) begin
      rd_q <= mem[rd_addr];
    end
  end

  // output payload, loaded alongside the memory read
  always_ff @(posedge clk_i) begin
    if (issue) begin
      gsel_q    <= gsel_d;
      lsel_q    <= lsel_d;
      asel_q    <= ~(8'(1) << grp_q);
      last_q    <= (grp_q == GroupW'(Groups - 1));
      written_q <= wrapped_q || (rd_addr < wr_idx_q);
      fill_q    <= col_ext[0] ? FILL_ODD : FILL_EVEN;
    end
  end

  // entries never written since reset read as the power-up pattern
  assign out_valid_o             = out_valid_q;
  assign out_data_o.group_select = gsel_q;
  assign out_data_o.line_select  = lsel_q;
  assign out_data_o.anode_select = asel_q;
  assign out_data_o.anode_data   = written_q ? rd_q : fill_q;
  assign out_data_o.last         = last_q;

  // assertions
  `LMS_ASSERT(a_wr_ptr_step, wr_en |=> (wr_idx_q == AddrW'($past(wr_idx_q) + AddrW'(1))), "write pointer did not advance by one")
  `LMS_ASSERT(a_anode_onecold, out_valid_o |-> $onehot(~out_data_o.anode_select), "anode select not one-cold")
  `LMS_ASSERT(a_col_advance, (issue && (grp_q == GroupW'(Groups - 1))) |=> (col_q != $past(col_q)), "scan column did not advance after a tick")
  `LMS_ASSERT_NEVER(a_accept_while_scan, in_fire && (state_q == ST_SCAN), "input accepted during a scan")

endmodule
